[rtl/smi_pkg.sv]
// Shared constants and types for the small matrix inverse block.
`timescale 1ns / 1ps
`default_nettype none
package smi_pkg;

   localparam int ELEM_WIDTH_DEF = 16;
   localparam int OUT_WIDTH_DEF  = 32;
   localparam int IN_FRAC        = 12;
   localparam int OUT_FRAC       = 16;
   localparam int N_ELEM         = 9;
   // register stages inside the cofactor front end
   localparam int COF_PIPE       = 4;

   // cofactor i = a[MA]*a[MB] - a[SA]*a[SB], sign of the adjugate folded in
   localparam int COF_MA [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_MB [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_SA [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int COF_SB [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   typedef struct packed {
      logic ovf;   // quotient does not fit the output magnitude
      logic neg;   // result sign
   } smi_lane_stat_type;

endpackage
`default_nettype wire

[rtl/smi_if.sv]
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface smi_req_if import smi_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic                         size_three;
   logic signed [ELEM_WIDTH-1:0] elem_00;
   logic signed [ELEM_WIDTH-1:0] elem_01;
   logic signed [ELEM_WIDTH-1:0] elem_02;
   logic signed [ELEM_WIDTH-1:0] elem_10;
   logic signed [ELEM_WIDTH-1:0] elem_11;
   logic signed [ELEM_WIDTH-1:0] elem_12;
   logic signed [ELEM_WIDTH-1:0] elem_20;
   logic signed [ELEM_WIDTH-1:0] elem_21;
   logic signed [ELEM_WIDTH-1:0] elem_22;

   modport source (output valid, size_three, elem_00, elem_01, elem_02, elem_10, elem_11,
                   elem_12, elem_20, elem_21, elem_22, input ready);
   modport sink (input valid, size_three, elem_00, elem_01, elem_02, elem_10, elem_11,
                 elem_12, elem_20, elem_21, elem_22, output ready);
endinterface

interface smi_rsp_if import smi_pkg::*; #(
   parameter int OUT_WIDTH = OUT_WIDTH_DEF
) ();
   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] inv_00;
   logic signed [OUT_WIDTH-1:0] inv_01;
   logic signed [OUT_WIDTH-1:0] inv_02;
   logic signed [OUT_WIDTH-1:0] inv_10;
   logic signed [OUT_WIDTH-1:0] inv_11;
   logic signed [OUT_WIDTH-1:0] inv_12;
   logic signed [OUT_WIDTH-1:0] inv_20;
   logic signed [OUT_WIDTH-1:0] inv_21;
   logic signed [OUT_WIDTH-1:0] inv_22;
   logic signed [OUT_WIDTH-1:0] determinant;
   logic                        singular;
   logic                        saturated;

   modport source (output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20,
                   inv_21, inv_22, determinant, singular, saturated, input ready);
   modport sink (input valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12, inv_20,
                 inv_21, inv_22, determinant, singular, saturated, output ready);
endinterface
`default_nettype wire

[rtl/smi_cofactor.sv]
// Pipelined cofactor and exact determinant front end.
`timescale 1ns / 1ps
`default_nettype none
module smi_cofactor import smi_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   localparam int PW = 2 * ELEM_WIDTH,
   localparam int CW = 2 * ELEM_WIDTH + 1,
   localparam int DW = 3 * ELEM_WIDTH + 1
) (
   input  logic                         clock,
   input  logic                         adv,
   input  logic                         three_i,
   input  logic signed [ELEM_WIDTH-1:0] elem_i [N_ELEM],
   output logic signed [CW-1:0]         cof_o [N_ELEM],
   output logic signed [DW-1:0]         det_o,
   output logic                         three_o
);

   // stage 1: minor products
   logic signed [PW-1:0]         pa_ff [N_ELEM];
   logic signed [PW-1:0]         pb_ff [N_ELEM];
   logic signed [ELEM_WIDTH-1:0] a1_ff [N_ELEM];
   logic                         t1_ff;
   // stage 2: cofactors
   logic signed [CW-1:0]         c2_in [N_ELEM];
   logic signed [CW-1:0]         c2_ff [N_ELEM];
   logic signed [ELEM_WIDTH-1:0] a2_ff [3];
   logic signed [DW-1:0]         d2_ff;
   logic                         t2_ff;
   // stage 3: first-row expansion terms
   logic signed [DW-1:0]         x3_ff [3];
   logic signed [CW-1:0]         c3_ff [N_ELEM];
   logic signed [DW-1:0]         d3_ff;
   logic                         t3_ff;
   // stage 4: determinant
   logic signed [CW-1:0]         c4_ff [N_ELEM];
   logic signed [DW-1:0]         d4_ff;
   logic                         t4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < N_ELEM; i++) begin
            pa_ff[i] <= elem_i[COF_MA[i]] * elem_i[COF_MB[i]];
            pb_ff[i] <= elem_i[COF_SA[i]] * elem_i[COF_SB[i]];
            a1_ff[i] <= elem_i[i];
         end
         t1_ff <= three_i;
      end
   end

   always_comb begin
      for (int i = 0; i < N_ELEM; i++) begin
         c2_in[i] = pa_ff[i] - pb_ff[i];
      end
      if (!t1_ff) begin
         // 2x2: adjugate of the top-left block, remaining entries zero
         for (int i = 0; i < N_ELEM; i++) begin
            c2_in[i] = '0;
         end
         c2_in[0] = CW'(a1_ff[4]);
         c2_in[1] = -CW'(a1_ff[1]);
         c2_in[3] = -CW'(a1_ff[3]);
         c2_in[4] = CW'(a1_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c2_ff <= c2_in;
         for (int k = 0; k < 3; k++) begin
            a2_ff[k] <= a1_ff[k];
         end
         // a00*a11 - a01*a10 is the 2x2 determinant
         d2_ff <= DW'(pa_ff[8] - pb_ff[8]);
         t2_ff <= t1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            x3_ff[k] <= a2_ff[k] * c2_ff[3 * k];
         end
         c3_ff <= c2_ff;
         d3_ff <= d2_ff;
         t3_ff <= t2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c4_ff <= c3_ff;
         d4_ff <= t3_ff ? (x3_ff[0] + x3_ff[1] + x3_ff[2]) : d3_ff;
         t4_ff <= t3_ff;
      end
   end

   assign cof_o   = c4_ff;
   assign det_o   = d4_ff;
   assign three_o = t4_ff;

endmodule
`default_nettype wire

[rtl/smi_div_lane.sv]
// One divider lane: round(cofactor * 2^28 / det), one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module smi_div_lane import smi_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
   localparam int CW  = 2 * ELEM_WIDTH + 1,
   localparam int DW  = 3 * ELEM_WIDTH + 1,
   localparam int SH  = IN_FRAC + OUT_FRAC + 1,
   localparam int NW  = ((2 * ELEM_WIDTH + SH > DW) ? 2 * ELEM_WIDTH + SH : DW) + 1,
   localparam int DSW = DW + 1 + OUT_WIDTH,
   localparam int WW  = (NW > DSW) ? NW : DSW
) (
   input  logic                  clock,
   input  logic                  adv,
   input  logic signed [CW-1:0]  cof_i,
   input  logic signed [DW-1:0]  det_i,
   output logic [OUT_WIDTH-1:0]  quot_o,
   output smi_lane_stat_type     stat_o
);

   logic [CW-1:0]     cmag;
   logic [DW-1:0]     dmag;
   logic [WW-1:0]     num;
   logic [DW:0]       den;
   smi_lane_stat_type st0;

   logic [WW-1:0]          r_ff  [OUT_WIDTH];
   logic [DW:0]            d_ff  [OUT_WIDTH];
   logic [OUT_WIDTH-1:0]   q_ff  [OUT_WIDTH+1];
   smi_lane_stat_type      st_ff [OUT_WIDTH+1];

   // rounding folded into the dividend: (2|c|*2^28 + |d|) / (2|d|)
   always_comb begin
      cmag    = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
      dmag    = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
      num     = (WW'(cmag) << SH) + WW'(dmag);
      den     = {dmag, 1'b0};
      st0.neg = cof_i[CW-1] != det_i[DW-1];
      st0.ovf = num >= (WW'(den) << OUT_WIDTH);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]  <= num;
         d_ff[0]  <= den;
         q_ff[0]  <= '0;
         st_ff[0] <= st0;
      end
   end

   for (genvar s = 1; s <= OUT_WIDTH; s++) begin : g_stage
      localparam int J = OUT_WIDTH - s;
      logic [WW-1:0] dsh;
      logic          take;

      assign dsh  = WW'(d_ff[s-1]) << J;
      assign take = r_ff[s-1] >= dsh;

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[s]  <= {q_ff[s-1][OUT_WIDTH-2:0], take};
            st_ff[s] <= st_ff[s-1];
         end
      end

      if (s < OUT_WIDTH) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               r_ff[s] <= take ? r_ff[s-1] - dsh : r_ff[s-1];
               d_ff[s] <= d_ff[s-1];
            end
         end
      end
   end

   assign quot_o = q_ff[OUT_WIDTH];
   assign stat_o = st_ff[OUT_WIDTH];

endmodule
`default_nettype wire

[rtl/smi_merge.sv]
// Merges lane quotients and the determinant into signed, saturated results.
`timescale 1ns / 1ps
`default_nettype none
module smi_merge import smi_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
   localparam int DW = 3 * ELEM_WIDTH + 1,
   localparam int MW = ((DW > OUT_WIDTH) ? DW : OUT_WIDTH) + 1
) (
   input  logic [OUT_WIDTH-1:0]        quot_i [N_ELEM],
   input  smi_lane_stat_type           stat_i [N_ELEM],
   input  logic signed [DW-1:0]        det_i,
   input  logic                        three_i,
   output logic signed [OUT_WIDTH-1:0] inv_o [N_ELEM],
   output logic signed [OUT_WIDTH-1:0] det_o,
   output logic                        singular_o,
   output logic                        saturated_o
);

   localparam int SH3 = 3 * IN_FRAC - OUT_FRAC;
   localparam int SH2 = 2 * IN_FRAC - OUT_FRAC;
   localparam logic [MW-1:0] POS_MAX = MW'((64'(1) << (OUT_WIDTH - 1)) - 64'(1));
   localparam logic [MW-1:0] NEG_MAG = MW'(64'(1) << (OUT_WIDTH - 1));
   localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = OUT_WIDTH'(POS_MAX);
   localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = OUT_WIDTH'(NEG_MAG);

   logic [DW-1:0] dmag;
   logic [DW-1:0] m3;
   logic [DW-1:0] m2;
   logic [MW-1:0] mdet;
   logic [MW-1:0] qx;
   logic          dneg;
   logic          sat;

   always_comb begin
      sat  = 1'b0;
      dneg = det_i[DW-1];
      dmag = dneg ? DW'(-det_i) : DW'(det_i);
      m3   = (dmag + DW'(64'(1) << (SH3 - 1))) >> SH3;
      m2   = (dmag + DW'(64'(1) << (SH2 - 1))) >> SH2;
      mdet = MW'(three_i ? m3 : m2);

      for (int i = 0; i < N_ELEM; i++) begin
         qx = MW'(quot_i[i]);
         if (stat_i[i].ovf || (!stat_i[i].neg && qx > POS_MAX) ||
             (stat_i[i].neg && qx > NEG_MAG)) begin
            sat      = 1'b1;
            inv_o[i] = stat_i[i].neg ? OUT_MIN : OUT_MAX;
         end else begin
            inv_o[i] = stat_i[i].neg ? -quot_i[i] : quot_i[i];
         end
      end

      if (!dneg && mdet > POS_MAX) begin
         sat   = 1'b1;
         det_o = OUT_MAX;
      end else if (dneg && mdet > NEG_MAG) begin
         sat   = 1'b1;
         det_o = OUT_MIN;
      end else begin
         det_o = dneg ? -OUT_WIDTH'(mdet) : OUT_WIDTH'(mdet);
      end

      singular_o  = det_i == '0;
      saturated_o = sat;
      if (singular_o) begin
         for (int i = 0; i < N_ELEM; i++) begin
            inv_o[i] = '0;
         end
         det_o       = '0;
         saturated_o = 1'b0;
      end
   end

endmodule
`default_nettype wire

[rtl/small_matrix_inverse.sv]
// Inverse of a 2x2 or 3x3 signed Q3.12 matrix by adjugate over determinant.
//
// Takes one matrix per clock while the skid slot is free and returns one result per
// matrix, in order. A request passes four stages of products, cofactors, expansion
// terms and determinant, one divider setup stage, then OUT_WIDTH restoring-division
// stages that each settle one quotient bit in all nine lanes at once. The response
// side has an output register and a skid slot, so requests keep flowing while one
// finished response waits. Results are Q15.16, rounded to nearest with ties away from
// zero and saturated; a zero determinant gives all zeros with singular set.
`timescale 1ns / 1ps
`default_nettype none
module small_matrix_inverse import smi_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int OUT_WIDTH  = OUT_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   smi_req_if.sink   req_ch,
   smi_rsp_if.source rsp_ch
);

   localparam int CW = 2 * ELEM_WIDTH + 1;
   localparam int DW = 3 * ELEM_WIDTH + 1;
   localparam int PL = COF_PIPE + 1 + OUT_WIDTH;
   localparam int DL = OUT_WIDTH + 1;
   localparam int RW = (N_ELEM + 1) * OUT_WIDTH + 2;

   logic                         adv;
   logic                         push;
   logic                         pop;
   logic [PL-1:0]                v_ff;
   logic [PL-1:0]                v_in;
   logic signed [ELEM_WIDTH-1:0] elem [N_ELEM];
   logic signed [CW-1:0]         cof [N_ELEM];
   logic signed [DW-1:0]         det_c;
   logic                         three_c;
   logic [OUT_WIDTH-1:0]         quot [N_ELEM];
   smi_lane_stat_type            stat [N_ELEM];
   logic signed [DW-1:0]         detd_ff [DL];
   logic                         thr_ff [DL];
   logic signed [OUT_WIDTH-1:0]  inv [N_ELEM];
   logic signed [OUT_WIDTH-1:0]  det_q;
   logic                         singular;
   logic                         saturated;
   logic [RW-1:0]                res;
   logic                         out_v_ff;
   logic                         out_v_in;
   logic                         sk_v_ff;
   logic                         sk_v_in;
   logic [RW-1:0]                out_d_ff;
   logic [RW-1:0]                sk_d_ff;

   assign elem[0] = req_ch.elem_00;
   assign elem[1] = req_ch.elem_01;
   assign elem[2] = req_ch.elem_02;
   assign elem[3] = req_ch.elem_10;
   assign elem[4] = req_ch.elem_11;
   assign elem[5] = req_ch.elem_12;
   assign elem[6] = req_ch.elem_20;
   assign elem[7] = req_ch.elem_21;
   assign elem[8] = req_ch.elem_22;

   // pipeline moves whenever the skid slot is free
   assign adv          = !sk_v_ff;
   assign req_ch.ready = adv;
   assign push         = adv && v_ff[PL-1];
   assign pop          = out_v_ff && rsp_ch.ready;
   assign v_in         = adv ? {v_ff[PL-2:0], req_ch.valid} : v_ff;

   smi_cofactor #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_cofactor (
      .clock   (clock),
      .adv     (adv),
      .three_i (req_ch.size_three),
      .elem_i  (elem),
      .cof_o   (cof),
      .det_o   (det_c),
      .three_o (three_c)
   );

   for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
      smi_div_lane #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .OUT_WIDTH  (OUT_WIDTH)
      ) u_lane (
         .clock  (clock),
         .adv    (adv),
         .cof_i  (cof[i]),
         .det_i  (det_c),
         .quot_o (quot[i]),
         .stat_o (stat[i])
      );
   end

   // determinant rides alongside the divider lanes
   always_ff @(posedge clock) begin
      if (adv) begin
         detd_ff[0] <= det_c;
         thr_ff[0]  <= three_c;
         for (int k = 1; k < DL; k++) begin
            detd_ff[k] <= detd_ff[k-1];
            thr_ff[k]  <= thr_ff[k-1];
         end
      end
   end

   smi_merge #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .OUT_WIDTH  (OUT_WIDTH)
   ) u_merge (
      .quot_i      (quot),
      .stat_i      (stat),
      .det_i       (detd_ff[DL-1]),
      .three_i     (thr_ff[DL-1]),
      .inv_o       (inv),
      .det_o       (det_q),
      .singular_o  (singular),
      .saturated_o (saturated)
   );

   always_comb begin
      for (int i = 0; i < N_ELEM; i++) begin
         res[(i+1)*OUT_WIDTH+1 +: OUT_WIDTH] = inv[i];
      end
      res[N_ELEM*OUT_WIDTH+OUT_WIDTH+1 +: 1] = 1'b0;
      res[RW-1 -: OUT_WIDTH] = det_q;
      res[1] = singular;
      res[0] = saturated;
      // element i sits below the determinant, element 0 highest
      for (int i = 0; i < N_ELEM; i++) begin
         res[RW-1-(i+1)*OUT_WIDTH -: OUT_WIDTH] = inv[i];
      end
   end

   always_comb begin
      out_v_in = out_v_ff;
      sk_v_in  = sk_v_ff;
      if (pop) begin
         if (sk_v_ff) begin
            sk_v_in = 1'b0;
         end else begin
            out_v_in = push;
         end
      end else if (push) begin
         if (out_v_ff) begin
            sk_v_in = 1'b1;
         end else begin
            out_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else begin
         v_ff     <= v_in;
         out_v_ff <= out_v_in;
         sk_v_ff  <= sk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && sk_v_ff) begin
         out_d_ff <= sk_d_ff;
      end else if (push && (pop || !out_v_ff)) begin
         out_d_ff <= res;
      end
      if (push && out_v_ff && !pop) begin
         sk_d_ff <= res;
      end
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.determinant = out_d_ff[RW-1 -: OUT_WIDTH];
   assign rsp_ch.inv_00      = out_d_ff[RW-1-1*OUT_WIDTH -: OUT_WIDTH];
   assign rsp_ch.inv_01      = out_d_ff[RW-1-2*OUT_WIDTH -: OUT_WIDTH];
   assign rsp_ch.inv_02      = out_d_ff[RW-1-3*OUT_WIDTH -: OUT_WIDTH];
   assign rsp_ch.inv_10      = out_d_ff[RW-1-4*OUT_WIDTH -: OUT_WIDTH];
   assign rsp_ch.inv_11      = out_d_ff[RW-1-5*OUT_WIDTH -: OUT_WIDTH];
   assign rsp_ch.inv_12      = out_d_ff[RW-1-6*OUT_WIDTH -: OUT_WIDTH];
   assign rsp_ch.inv_20      = out_d_ff[RW-1-7*OUT_WIDTH -: OUT_WIDTH];
   assign rsp_ch.inv_21      = out_d_ff[RW-1-8*OUT_WIDTH -: OUT_WIDTH];
   assign rsp_ch.inv_22      = out_d_ff[RW-1-9*OUT_WIDTH -: OUT_WIDTH];
   assign rsp_ch.singular    = out_d_ff[1];
   assign rsp_ch.saturated   = out_d_ff[0];

   // skid slot only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> out_v_ff)
      else $error("skid slot full with output register empty");

   // a stalled skid entry must not vanish
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (sk_v_ff && !rsp_ch.ready) |=> sk_v_ff)
      else $error("skid entry lost while response stalled");

   // singular response carries a zero determinant and no saturation
   a_singular_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.singular) |-> (rsp_ch.determinant == '0 && !rsp_ch.saturated))
      else $error("singular response with nonzero determinant or saturation");

endmodule
`default_nettype wire
